FILE: rtl/mcq_pkg.sv
// Package for the motion command queue.
// Holds the item structs, command and status codes, register indexes and sizes.
// No dependencies.
package mcq_pkg;

	// Default number of queue slots. The queue holds one less command than this.
	localparam int QUEUE_DEPTH = 16;

	// Field and register widths.
	localparam int AMOUNT_W  = 24;
	localparam int FACTOR_W  = 24;
	localparam int SEG_W     = 23;
	localparam int STEPS_W   = 32;
	localparam int ENTRY_W   = AMOUNT_W + 1;
	localparam int PRODUCT_W = AMOUNT_W + FACTOR_W;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 2;

	// Reset values of the configuration registers.
	localparam logic [FACTOR_W-1:0] STEPS_PER_CM_RST     = 24'd65536;
	localparam logic [FACTOR_W-1:0] STEPS_PER_DEGREE_RST = 24'd65536;
	localparam logic [SEG_W-1:0]    MAX_SEGMENT_RST      = 23'd25600;

	// Command codes.
	localparam logic [1:0] CMD_FORWARD = 2'd0;
	localparam logic [1:0] CMD_TURN    = 2'd1;
	localparam logic [1:0] CMD_POLL    = 2'd2;

	// Status codes.
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_CM     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_DEGREE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEGMENT      = 2'd2;

	// Kind bit of a queue entry.
	localparam logic KIND_FORWARD = 1'b0;
	localparam logic KIND_TURN    = 1'b1;

	// Input item.
	typedef struct packed {
		logic [1:0]                 command;
		logic signed [AMOUNT_W-1:0] amount;
		logic                       motors_idle;
	} cmd_item_t;

	// Result item.
	typedef struct packed {
		logic [1:0]                status;
		logic                      load_right;
		logic signed [STEPS_W-1:0] right_steps;
		logic                      load_left;
		logic signed [STEPS_W-1:0] left_steps;
		logic                      queue_empty;
		logic                      all_done;
	} res_item_t;

endpackage

FILE: rtl/mcq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the command slots of the motion command queue. No dependencies.
module mcq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/motion_command_queue.sv
// Motion command queue: ring of drive commands for a two-wheel stepper drive.
// A turn, an ignored item or a poll with nothing to hand out goes from idle straight to the final state;
// a dispatching poll passes the multiply state first, a forward move the split loop (one segment per pass).
// One item at a time: the next is taken the cycle after the result loads, a stalled result
// holds the block, the split writes one slot a cycle and a dispatch runs one 24x24 multiply.
// Reset (arst_n low) empties the queue and loads the default step factors and segment.
module motion_command_queue #(
	parameter int QUEUE_DEPTH = mcq_pkg::QUEUE_DEPTH,
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  mcq_pkg::cmd_item_t            cmd,
	output logic                          res_valid,
	input  logic                          res_stall,
	output mcq_pkg::res_item_t            res,
	input  logic                          cfg_we,
	input  logic [mcq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mcq_pkg::CFG_W-1:0]     cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SPLIT = 4'b0010,
		ST_MUL   = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);

	state_t state_q;

	logic [mcq_pkg::FACTOR_W-1:0] steps_per_cm_q;
	logic [mcq_pkg::FACTOR_W-1:0] steps_per_degree_q;
	logic [mcq_pkg::SEG_W-1:0]    max_segment_q;

	logic [AW-1:0] wr_q, rd_q, wr_next, rd_next;
	logic          full, empty;

	logic [1:0]                    status_q;
	logic                          idle_q;
	logic                          first_q;
	logic [mcq_pkg::SEG_W-1:0]     remaining_q;
	logic                          dispatch_q;
	logic                          kind_q;
	logic                          neg_q;
	logic                          pos_q;
	logic [mcq_pkg::PRODUCT_W-1:0] product_q;

	logic                          ram_we, ram_re;
	logic [AW-1:0]                 ram_waddr;
	logic [mcq_pkg::ENTRY_W-1:0]   ram_wdata, ram_rdata;

	logic                          accept;
	logic                          fwd_positive;
	logic                          can_dispatch;
	logic [mcq_pkg::SEG_W-1:0]     seg;
	logic [mcq_pkg::SEG_W:0]       diff;
	logic                          last_piece;
	logic [mcq_pkg::SEG_W-1:0]     piece;
	logic signed [mcq_pkg::AMOUNT_W-1:0] entry_amount;
	logic [mcq_pkg::AMOUNT_W-1:0]  entry_mag;
	logic [mcq_pkg::FACTOR_W-1:0]  factor;
	logic [mcq_pkg::STEPS_W-1:0]   steps, neg_steps;
	logic                          res_free;
	mcq_pkg::res_item_t            res_d;

	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign res_free  = !(res_valid && res_stall);

	// Ring indexes advance before use, wrapping at the last slot.
	assign wr_next = (wr_q == LAST_SLOT) ? '0 : wr_q + AW'(1);
	assign rd_next = (rd_q == LAST_SLOT) ? '0 : rd_q + AW'(1);
	assign full    = (wr_next == rd_q);
	assign empty   = (wr_q == rd_q);

	assign fwd_positive = !cmd.amount[mcq_pkg::AMOUNT_W-1] && (cmd.amount != '0);
	assign can_dispatch = cmd.motors_idle && !empty;

	// Shared subtractor of the split loop: compares the rest with the segment limit.
	assign seg        = (max_segment_q == '0) ? mcq_pkg::SEG_W'(1) : max_segment_q;
	assign diff       = {1'b0, remaining_q} - {1'b0, seg};
	assign last_piece = diff[mcq_pkg::SEG_W] || (diff[mcq_pkg::SEG_W-1:0] == '0);
	assign piece      = last_piece ? remaining_q : seg;

	// Queue write port: a turn on accept, forward pieces in the split loop.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_next;
		ram_wdata = {mcq_pkg::KIND_FORWARD, 1'b0, piece};
		if (state_q == ST_IDLE && accept && cmd.command == mcq_pkg::CMD_TURN && !full) begin
			ram_we    = 1'b1;
			ram_wdata = {mcq_pkg::KIND_TURN, cmd.amount};
		end else if (state_q == ST_SPLIT && !full) begin
			ram_we = 1'b1;
		end
	end

	assign ram_re = accept && cmd.command == mcq_pkg::CMD_POLL && can_dispatch;

	mcq_ram #(
		.WIDTH(mcq_pkg::ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_next),
		.rdata (ram_rdata)
	);

	// Magnitude of the dispatched entry and the factor for its kind.
	assign entry_amount = ram_rdata[mcq_pkg::AMOUNT_W-1:0];
	assign entry_mag    = entry_amount[mcq_pkg::AMOUNT_W-1] ? (~entry_amount + 1'b1)
	                                                         : entry_amount;
	assign factor       = ram_rdata[mcq_pkg::AMOUNT_W] ? steps_per_degree_q : steps_per_cm_q;

	// Whole steps from the Q.8 by Q8.16 product, and their negation.
	assign steps     = mcq_pkg::STEPS_W'(product_q[mcq_pkg::PRODUCT_W-1:mcq_pkg::AMOUNT_W]);
	assign neg_steps = '0 - steps;

	// Result assembled from the registers of the finished item.
	always_comb begin
		res_d             = '0;
		res_d.status      = status_q;
		res_d.queue_empty = empty;
		res_d.all_done    = empty && idle_q;
		if (dispatch_q) begin
			if (kind_q == mcq_pkg::KIND_FORWARD) begin
				res_d.load_right  = 1'b1;
				res_d.load_left   = 1'b1;
				res_d.right_steps = neg_q ? neg_steps : steps;
				res_d.left_steps  = neg_q ? steps : neg_steps;
			end else if (pos_q) begin
				res_d.load_left  = 1'b1;
				res_d.left_steps = neg_steps;
			end else begin
				res_d.load_right  = 1'b1;
				res_d.right_steps = steps;
			end
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_per_cm_q     <= mcq_pkg::STEPS_PER_CM_RST;
			steps_per_degree_q <= mcq_pkg::STEPS_PER_DEGREE_RST;
			max_segment_q      <= mcq_pkg::MAX_SEGMENT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mcq_pkg::CFG_STEPS_PER_CM:     steps_per_cm_q     <= cfg_data;
				mcq_pkg::CFG_STEPS_PER_DEGREE: steps_per_degree_q <= cfg_data;
				mcq_pkg::CFG_MAX_SEGMENT:      max_segment_q <= cfg_data[mcq_pkg::SEG_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and queue indexes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wr_q    <= '0;
			rd_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd.command)
							mcq_pkg::CMD_FORWARD: begin
								state_q <= fwd_positive ? ST_SPLIT : ST_FIN;
							end
							mcq_pkg::CMD_TURN: begin
								if (!full) begin
									wr_q <= wr_next;
								end
								state_q <= ST_FIN;
							end
							mcq_pkg::CMD_POLL: begin
								if (can_dispatch) begin
									rd_q    <= rd_next;
									state_q <= ST_MUL;
								end else begin
									state_q <= ST_FIN;
								end
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_SPLIT: begin
					if (full) begin
						state_q <= ST_FIN;
					end else begin
						wr_q <= wr_next;
						if (last_piece) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_MUL: state_q <= ST_FIN;
				ST_FIN: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers of the current item.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					idle_q      <= cmd.motors_idle;
					first_q     <= 1'b1;
					remaining_q <= cmd.amount[mcq_pkg::SEG_W-1:0];
					dispatch_q  <= (cmd.command == mcq_pkg::CMD_POLL) && can_dispatch;
					status_q    <= (cmd.command == mcq_pkg::CMD_TURN && full)
					               ? mcq_pkg::STATUS_FULL : mcq_pkg::STATUS_OK;
				end
			end
			ST_SPLIT: begin
				if (full) begin
					status_q <= first_q ? mcq_pkg::STATUS_FULL : mcq_pkg::STATUS_TRUNCATED;
				end else begin
					first_q     <= 1'b0;
					remaining_q <= last_piece ? '0 : diff[mcq_pkg::SEG_W-1:0];
				end
			end
			ST_MUL: begin
				kind_q    <= ram_rdata[mcq_pkg::AMOUNT_W];
				neg_q     <= entry_amount[mcq_pkg::AMOUNT_W-1];
				pos_q     <= !entry_amount[mcq_pkg::AMOUNT_W-1] && (entry_amount != '0);
				product_q <= entry_mag * factor;
			end
			default: ;
		endcase
	end

	// Output register: holds the result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (state_q == ST_FIN && res_free) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && res_free) begin
			res <= res_d;
		end
	end

	// A new result is only loaded from the final state of the sequencer.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q == ST_FIN))
		else $error("result raised outside the final state");

	// A queue write never leaves the ring looking empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (wr_q != rd_q))
		else $error("queue write made the ring appear empty");

	// The split loop never runs with nothing left to queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SPLIT) |-> (remaining_q != '0))
		else $error("split loop running with no distance left");

endmodule
